### rtl/core/iolam_pkg.sv
// Shared types and codes for the I/O latency accounting monitor.
`timescale 1ns / 1ps

package iolam_pkg;

   localparam logic [1:0] OP_ENTER = 2'd0;
   localparam logic [1:0] OP_EXIT  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [2:0] OUT_RECORDED = 3'd0;
   localparam logic [2:0] OUT_IGNORED  = 3'd1;
   localparam logic [2:0] OUT_NESTING  = 3'd2;
   localparam logic [2:0] OUT_UNPAIRED = 3'd3;
   localparam logic [2:0] OUT_FULL     = 3'd4;
   localparam logic [2:0] OUT_FAILED   = 3'd5;
   localparam logic [2:0] OUT_READ     = 3'd6;

   localparam logic [3:0] SEL_RD_BYTES = 4'd0;
   localparam logic [3:0] SEL_WR_BYTES = 4'd3;
   localparam logic [3:0] SEL_FAILED   = 4'd6;
   localparam logic [3:0] SEL_RD_HIST  = 4'd7;
   localparam logic [3:0] SEL_WR_HIST  = 4'd8;
   localparam logic [3:0] SEL_OVERFLOW = 4'd9;
   localparam logic [3:0] SEL_UNPAIRED = 4'd10;

   // categories below this code are never counted
   localparam logic [2:0] FIRST_STAT_CAT = 3'd2;
   // bytes/ops/ns for read and write, then failed ops
   localparam int STAT_FIXED = 7;
   localparam logic [7:0] NEST_MAX = 8'hFF;

   typedef struct packed {
      logic [63:0] thread;
      logic [63:0] start_time;
      logic [7:0]  nesting;
   } entry_type;

endpackage

### rtl/core/io_latency_accounting_monitor_top.sv
// Top level of the I/O latency accounting monitor: control sequencer and memories.
`timescale 1ns / 1ps

// Tracks nested enter/exit operations per thread in an in-flight table and
// accumulates per-process, per-category bytes, ops, time and log2 latency
// histograms in a statistics RAM. A word is taken when start is high and busy
// is low; exactly one response word follows, shown for one cycle with
// rsp_valid high, and the receiver cannot stall it. Enter and exit scan the
// in-flight table one entry per cycle through its RAM read port (the scan
// stops early on a hit); an outermost exit that is counted then finds the
// bucket (skipped for a failure) and makes a read and a write per counter
// update (4 updates, or 1 for a failure) on the single statistics RAM port.
// A counter read goes through the RAM read port, but the overflow or unpaired
// count and an unusable select are answered without it, and an ignored enter
// is answered straight from idle. After reset the statistics RAM is cleared
// one word per cycle, PROCESS_SLOTS * STAT_CATEGORIES * (7 + 2 * HIST_BUCKETS)
// words (4544 by default); busy stays high during that pass. All counters
// wrap at 2^64.

module io_latency_accounting_monitor_top
   import iolam_pkg::*;
#(
   parameter int INFLIGHT_ENTRIES = 64,
   parameter int PROCESS_SLOTS    = 16,
   parameter int HIST_BUCKETS     = 32,
   parameter int STAT_CATEGORIES  = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [63:0]        req_thread_id,
   input  logic [3:0]         req_process_slot,
   input  logic               req_process_registered,
   input  logic               req_owner_current,
   input  logic [2:0]         req_file_category,
   input  logic               req_is_write,
   input  logic signed [31:0] req_result_bytes,
   input  logic [63:0]        req_now_ns,
   input  logic [3:0]         req_counter_select,
   input  logic [4:0]         req_bucket_index,
   output logic               rsp_valid,
   output logic [2:0]         rsp_outcome,
   output logic [63:0]        rsp_read_value
);

   localparam int EW = (INFLIGHT_ENTRIES > 1) ? $clog2(INFLIGHT_ENTRIES) : 1;
   localparam int STRIDE = STAT_FIXED + 2 * HIST_BUCKETS;
   localparam int STAT_WORDS = PROCESS_SLOTS * STAT_CATEGORIES * STRIDE;
   localparam int SW = $clog2(STAT_WORDS);
   localparam int BW = $clog2(HIST_BUCKETS);
   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_SCAN   = 11'b000_0000_0100,
      S_DECIDE = 11'b000_0000_1000,
      S_BKT1   = 11'b000_0001_0000,
      S_BKT2   = 11'b000_0010_0000,
      S_URD    = 11'b000_0100_0000,
      S_UWR    = 11'b000_1000_0000,
      S_SRD    = 11'b001_0000_0000,
      S_SRSP   = 11'b010_0000_0000,
      S_SPARE  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // latched request word
   logic [1:0]  op_ff;
   logic [63:0] tid_ff;
   logic [3:0]  proc_ff;
   logic        reg_ff, owner_ff, wr_ff;
   logic [2:0]  fcat_ff;
   logic [31:0] rb_ff;
   logic [63:0] now_ff;
   logic [3:0]  sel_ff;
   logic [4:0]  bin_ff;

   // in-flight table
   logic [INFLIGHT_ENTRIES-1:0] valid_ff, valid_in;
   logic [EW:0]   issue_ff, issue_in;
   logic          chk_ff, chk_in;
   logic [EW-1:0] chk_idx_ff, chk_idx_in;
   logic          hit_ff, hit_in;
   logic [EW-1:0] hit_idx_ff, hit_idx_in;
   logic [63:0]   hit_start_ff, hit_start_in;
   logic [7:0]    hit_nest_ff, hit_nest_in;
   logic          free_ok_ff, free_ok_in;
   logic [EW-1:0] free_idx_ff, free_idx_in;

   logic               ent_we;
   logic [EW-1:0]      ent_waddr, ent_raddr;
   entry_type          ent_wdata, ent_rd;
   logic [ENTRY_W-1:0] ent_rdata;

   // statistics path
   logic [SW-1:0] clr_ff, clr_in;
   logic [63:0]   delta_ff, delta_in;
   logic          fail_ff, fail_in;
   logic [1:0]    step_ff, step_in;
   logic [BW-1:0] bucket;
   logic [63:0]   overflow_ff, overflow_in;
   logic [63:0]   unpaired_ff, unpaired_in;

   logic          st_we;
   logic [SW-1:0] st_waddr, st_raddr;
   logic [63:0]   st_wdata, st_rdata;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [63:0] rsp_value_ff, rsp_value_in;

   logic        accept;
   logic        proc_ok, cat_ok, base_ok, rd_ok, upd_last;
   logic [31:0] base, rd_off, upd_off;
   logic [SW-1:0] rd_addr, upd_addr;
   logic [63:0] upd_add;
   logic        counted;

   iolam_ram #(.WIDTH(ENTRY_W), .DEPTH(INFLIGHT_ENTRIES), .AW(EW)) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   iolam_ram #(.WIDTH(64), .DEPTH(STAT_WORDS), .AW(SW)) u_stat_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   iolam_bucket #(.HIST_BUCKETS(HIST_BUCKETS), .BW(BW)) u_bucket (
      .clock  (clock),
      .delta  (delta_ff),
      .bucket (bucket)
   );

   assign ent_rd = entry_type'(ent_rdata);
   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // stat block base and offsets
   always_comb begin
      proc_ok = 32'(proc_ff) < 32'(PROCESS_SLOTS);
      cat_ok  = (fcat_ff >= FIRST_STAT_CAT) &&
                ((32'(fcat_ff) - 32'(FIRST_STAT_CAT)) < 32'(STAT_CATEGORIES));
      base_ok = proc_ok && cat_ok;
      base    = (32'(proc_ff) * 32'(STAT_CATEGORIES) + 32'(fcat_ff)
                 - 32'(FIRST_STAT_CAT)) * 32'(STRIDE);

      if (sel_ff <= SEL_FAILED) begin
         rd_off = 32'(sel_ff);
      end else begin
         rd_off = 32'(STAT_FIXED) + ((sel_ff == SEL_WR_HIST) ? 32'(HIST_BUCKETS) : 32'd0)
                  + 32'(bin_ff);
      end
      rd_ok = base_ok && ((sel_ff <= SEL_FAILED) ||
              (((sel_ff == SEL_RD_HIST) || (sel_ff == SEL_WR_HIST)) &&
               (32'(bin_ff) < 32'(HIST_BUCKETS))));
      rd_addr = SW'(base + rd_off);

      upd_last = fail_ff || (step_ff == 2'd3);
      if (fail_ff) begin
         upd_off = 32'(SEL_FAILED);
         upd_add = 64'd1;
      end else begin
         case (step_ff)
            2'd0: begin
               upd_off = 32'(wr_ff ? SEL_WR_BYTES : SEL_RD_BYTES);
               upd_add = {32'd0, rb_ff};
            end
            2'd1: begin
               upd_off = 32'(wr_ff ? SEL_WR_BYTES : SEL_RD_BYTES) + 32'd1;
               upd_add = 64'd1;
            end
            2'd2: begin
               upd_off = 32'(wr_ff ? SEL_WR_BYTES : SEL_RD_BYTES) + 32'd2;
               upd_add = delta_ff;
            end
            default: begin
               upd_off = 32'(STAT_FIXED) + (wr_ff ? 32'(HIST_BUCKETS) : 32'd0) + 32'(bucket);
               upd_add = 64'd1;
            end
         endcase
      end
      upd_addr = SW'(base + upd_off);
      counted  = reg_ff && owner_ff && base_ok;
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      issue_in     = issue_ff;
      chk_in       = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_start_in = hit_start_ff;
      hit_nest_in  = hit_nest_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      clr_in       = clr_ff;
      delta_in     = delta_ff;
      fail_in      = fail_ff;
      step_in      = step_ff;
      overflow_in  = overflow_ff;
      unpaired_in  = unpaired_ff;
      rsp_valid_in   = 1'b0;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_value_in   = 64'd0;

      ent_we    = 1'b0;
      ent_waddr = hit_idx_ff;
      ent_wdata = '{thread: tid_ff, start_time: hit_start_ff, nesting: hit_nest_ff};
      ent_raddr = issue_ff[EW-1:0];
      st_we     = 1'b0;
      st_waddr  = upd_addr;
      st_wdata  = st_rdata + upd_add;
      st_raddr  = upd_addr;

      unique case (state_ff)
         S_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = clr_ff;
            st_wdata = 64'd0;
            clr_in   = clr_ff + SW'(1);
            if (32'(clr_ff) == 32'(STAT_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               issue_in   = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               if ((req_operation == OP_ENTER && req_process_registered) ||
                   req_operation == OP_EXIT) begin
                  state_in = S_SCAN;
               end else if (req_operation == OP_READ) begin
                  state_in = S_SRD;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = OUT_IGNORED;
               end
            end
         end
         S_SCAN: begin
            // read entry issue_ff while checking the one read last cycle
            if (issue_ff < (EW+1)'(INFLIGHT_ENTRIES)) begin
               issue_in   = issue_ff + (EW+1)'(1);
               chk_in     = 1'b1;
               chk_idx_in = issue_ff[EW-1:0];
            end
            if (chk_ff) begin
               if (!valid_ff[chk_idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (valid_ff[chk_idx_ff] && ent_rd.thread == tid_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = chk_idx_ff;
                  hit_start_in = ent_rd.start_time;
                  hit_nest_in  = ent_rd.nesting;
                  state_in     = S_DECIDE;
               end
            end else if (issue_ff == (EW+1)'(INFLIGHT_ENTRIES)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            if (op_ff == OP_ENTER) begin
               if (hit_ff) begin
                  ent_we = 1'b1;
                  ent_wdata.nesting = (hit_nest_ff == NEST_MAX) ? NEST_MAX
                                                                : hit_nest_ff + 8'd1;
                  rsp_outcome_in = OUT_NESTING;
               end else if (free_ok_ff) begin
                  ent_we    = 1'b1;
                  ent_waddr = free_idx_ff;
                  ent_wdata = '{thread: tid_ff, start_time: now_ff, nesting: 8'd0};
                  valid_in[free_idx_ff] = 1'b1;
                  rsp_outcome_in = OUT_RECORDED;
               end else begin
                  overflow_in    = overflow_ff + 64'd1;
                  rsp_outcome_in = OUT_FULL;
               end
            end else if (!hit_ff) begin
               if (reg_ff) begin
                  unpaired_in    = unpaired_ff + 64'd1;
                  rsp_outcome_in = OUT_UNPAIRED;
               end else begin
                  rsp_outcome_in = OUT_IGNORED;
               end
            end else if (hit_nest_ff != 8'd0) begin
               ent_we = 1'b1;
               ent_wdata.nesting = hit_nest_ff - 8'd1;
               rsp_outcome_in = OUT_NESTING;
            end else begin
               valid_in[hit_idx_ff] = 1'b0;
               rsp_outcome_in = OUT_IGNORED;
               if (counted) begin
                  rsp_valid_in = 1'b0;
                  delta_in = (now_ff > hit_start_ff) ? now_ff - hit_start_ff : 64'd0;
                  fail_in  = rb_ff[31];
                  step_in  = 2'd0;
                  state_in = rb_ff[31] ? S_URD : S_BKT1;
               end
            end
         end
         S_BKT1: begin
            state_in = S_BKT2;
         end
         S_BKT2: begin
            state_in = S_URD;
         end
         S_URD: begin
            state_in = S_UWR;
         end
         S_UWR: begin
            st_we = 1'b1;
            if (upd_last) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = fail_ff ? OUT_FAILED : OUT_RECORDED;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = S_URD;
            end
         end
         S_SRD: begin
            st_raddr = rd_addr;
            rsp_outcome_in = OUT_READ;
            if (sel_ff == SEL_OVERFLOW) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = overflow_ff;
               state_in     = S_IDLE;
            end else if (sel_ff == SEL_UNPAIRED) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = unpaired_ff;
               state_in     = S_IDLE;
            end else if (rd_ok) begin
               state_in = S_SRSP;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SRSP: begin
            rsp_valid_in   = 1'b1;
            rsp_outcome_in = OUT_READ;
            rsp_value_in   = st_rdata;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         valid_ff     <= '0;
         clr_ff       <= '0;
         chk_ff       <= 1'b0;
         overflow_ff  <= 64'd0;
         unpaired_ff  <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         clr_ff       <= clr_in;
         chk_ff       <= chk_in;
         overflow_ff  <= overflow_in;
         unpaired_ff  <= unpaired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         tid_ff   <= req_thread_id;
         proc_ff  <= req_process_slot;
         reg_ff   <= req_process_registered;
         owner_ff <= req_owner_current;
         fcat_ff  <= req_file_category;
         wr_ff    <= req_is_write;
         rb_ff    <= req_result_bytes;
         now_ff   <= req_now_ns;
         sel_ff   <= req_counter_select;
         bin_ff   <= req_bucket_index;
      end
      issue_ff       <= issue_in;
      chk_idx_ff     <= chk_idx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      hit_start_ff   <= hit_start_in;
      hit_nest_ff    <= hit_nest_in;
      free_ok_ff     <= free_ok_in;
      free_idx_ff    <= free_idx_in;
      delta_ff       <= delta_in;
      fail_ff        <= fail_in;
      step_ff        <= step_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_value_ff   <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_outcome    = rsp_outcome_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

### rtl/core/iolam_ram.sv
// Simple dual-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module iolam_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/iolam_bucket.sv
// Two-stage log2 bucket finder for a 64-bit latency, clamped to the last bin.
`timescale 1ns / 1ps

module iolam_bucket #(
   parameter int HIST_BUCKETS = 32,
   parameter int BW = 5
) (
   input  logic          clock,
   input  logic [63:0]   delta,
   output logic [BW-1:0] bucket
);

   logic [2:0]    byte_idx_ff, byte_idx_in;
   logic [7:0]    byte_ff, byte_in;
   logic [2:0]    bit_idx;
   logic [5:0]    msb;
   logic [BW-1:0] bucket_ff, bucket_in;

   // stage 1: highest nonzero byte
   always_comb begin
      byte_idx_in = 3'd0;
      for (int g = 0; g < 8; g++) begin
         if (delta[g*8 +: 8] != 8'd0) begin
            byte_idx_in = 3'(g);
         end
      end
      byte_in = delta[byte_idx_in*8 +: 8];
   end

   // stage 2: highest set bit inside it
   always_comb begin
      bit_idx = 3'd0;
      for (int b = 0; b < 8; b++) begin
         if (byte_ff[b]) begin
            bit_idx = 3'(b);
         end
      end
      msb = {byte_idx_ff, bit_idx};
      if (32'(msb) >= 32'(HIST_BUCKETS - 1)) begin
         bucket_in = BW'(HIST_BUCKETS - 1);
      end else begin
         bucket_in = BW'(msb);
      end
   end

   always_ff @(posedge clock) begin
      byte_idx_ff <= byte_idx_in;
      byte_ff     <= byte_in;
      bucket_ff   <= bucket_in;
   end

   assign bucket = bucket_ff;

endmodule

### tb/tb.sv
// Testbench for the I/O latency accounting monitor top level.
`timescale 1ns / 1ps

module tb;
   import iolam_pkg::*;

   localparam int ENTRIES    = 64;
   localparam int BUCKETS    = 32;
   localparam int STRIDE     = STAT_FIXED + 2 * BUCKETS;
   localparam int STAT_WORDS = 16 * 4 * STRIDE;
   localparam int WATCHDOG   = 20000;  // quiet cycles allowed before the bench gives up
   localparam int DRAIN      = 100;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // one command word as presented on the req_ ports
   typedef struct packed {
      logic [1:0]         op;
      logic [63:0]        tid;
      logic [3:0]         proc;
      logic               registered;
      logic               owner;
      logic [2:0]         cat;
      logic               wr;
      logic signed [31:0] rb;
      logic [63:0]        now;
      logic [3:0]         sel;
      logic [4:0]         bin;
   } io_word_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic rsp_valid;
   logic [2:0] rsp_outcome;
   logic [63:0] rsp_read_value;
   io_word_type drv;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   io_latency_accounting_monitor_top u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_operation          (drv.op),
      .req_thread_id          (drv.tid),
      .req_process_slot       (drv.proc),
      .req_process_registered (drv.registered),
      .req_owner_current      (drv.owner),
      .req_file_category      (drv.cat),
      .req_is_write           (drv.wr),
      .req_result_bytes       (drv.rb),
      .req_now_ns             (drv.now),
      .req_counter_select     (drv.sel),
      .req_bucket_index       (drv.bin),
      .rsp_valid              (rsp_valid),
      .rsp_outcome            (rsp_outcome),
      .rsp_read_value         (rsp_read_value)
   );

   // ---------------------------------------------------------------------
   // Shadow state of the monitor: in-flight table and statistics store.
   // ---------------------------------------------------------------------
   logic        live_valid [ENTRIES];
   logic [63:0] live_tid   [ENTRIES];
   logic [63:0] live_start [ENTRIES];
   logic [7:0]  live_depth [ENTRIES];
   logic [63:0] stats [STAT_WORDS];
   logic [63:0] overflow_total;
   logic [63:0] unpaired_total;

   // expected responses, oldest first
   logic [2:0]  want_outcome [$];
   logic [63:0] want_value [$];

   int mismatches = 0;
   int send_idle_pct = 0;
   logic [63:0] clock_ns = 64'd1000;
   logic [63:0] tid_pool [72];

   // Base word of a (process, category) block, -1 when the category is not counted.
   function automatic int stat_block(logic [3:0] proc, logic [2:0] cat);
      if (cat < FIRST_STAT_CAT || cat > 3'd5) return -1;
      return (int'(proc) * 4 + int'(cat - FIRST_STAT_CAT)) * STRIDE;
   endfunction

   // log2 histogram bin: highest set bit, clamped to the last bin
   function automatic int latency_bin(logic [63:0] delta);
      int b;
      b = 0;
      for (int i = 0; i < 64; i++)
         if (delta[i]) b = i;
      return (b >= BUCKETS) ? BUCKETS - 1 : b;
   endfunction

   // Applies one accepted word to the shadow state and returns its response.
   task automatic account_word(input io_word_type w, output logic [2:0] oc,
                               output logic [63:0] val);
      int hit;
      int base;
      int b;
      logic [63:0] delta;
      hit = -1;
      oc = OUT_IGNORED;
      val = '0;
      for (int i = 0; i < ENTRIES; i++)
         if (hit < 0 && live_valid[i] && live_tid[i] == w.tid) hit = i;
      case (w.op)
         OP_ENTER: begin
            if (w.registered) begin
               if (hit >= 0) begin
                  if (live_depth[hit] != NEST_MAX) live_depth[hit]++;
                  oc = OUT_NESTING;
               end else begin
                  for (int i = ENTRIES - 1; i >= 0; i--)
                     if (!live_valid[i]) hit = i;
                  if (hit >= 0) begin
                     live_valid[hit] = 1'b1;
                     live_tid[hit] = w.tid;
                     live_start[hit] = w.now;
                     live_depth[hit] = '0;
                     oc = OUT_RECORDED;
                  end else begin
                     overflow_total++;
                     oc = OUT_FULL;
                  end
               end
            end
         end
         OP_EXIT: begin
            if (hit < 0) begin
               if (w.registered) begin
                  unpaired_total++;
                  oc = OUT_UNPAIRED;
               end
            end else if (live_depth[hit] != 0) begin
               live_depth[hit]--;
               oc = OUT_NESTING;
            end else begin
               live_valid[hit] = 1'b0;
               base = stat_block(w.proc, w.cat);
               if (w.registered && w.owner && base >= 0) begin
                  delta = (w.now > live_start[hit]) ? w.now - live_start[hit] : '0;
                  b = latency_bin(delta);
                  if (w.rb[31]) begin
                     stats[base + SEL_FAILED]++;
                     oc = OUT_FAILED;
                  end else begin
                     // read group at 0..2, write group at 3..5
                     if (w.wr) base = base + SEL_WR_BYTES;
                     stats[base] += {32'd0, w.rb};
                     stats[base + 1]++;
                     stats[base + 2] += delta;
                     if (w.wr) base = base - SEL_WR_BYTES + BUCKETS;
                     stats[base + SEL_RD_HIST + b]++;
                     oc = OUT_RECORDED;
                  end
               end
            end
         end
         OP_READ: begin
            oc = OUT_READ;
            base = stat_block(w.proc, w.cat);
            if (w.sel == SEL_OVERFLOW) val = overflow_total;
            else if (w.sel == SEL_UNPAIRED) val = unpaired_total;
            else if (w.sel <= SEL_WR_HIST && base >= 0) begin
               if (w.sel <= SEL_FAILED) val = stats[base + w.sel];
               else val = stats[base + SEL_RD_HIST + (w.sel == SEL_WR_HIST ? BUCKETS : 0)
                                + w.bin];
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Response checker and predictor, both on the same edge. Responses are
   // compared before the word accepted at this edge is queued.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [2:0]  oc;
      logic [63:0] val;
      if (!reset) begin
         if (rsp_valid) begin
            if (want_outcome.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with none expected: outcome %0d value %h",
                           $realtime, rsp_outcome, rsp_read_value);
            end else begin
               oc = want_outcome.pop_front();
               val = want_value.pop_front();
               if (rsp_outcome !== oc || rsp_read_value !== val) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected outcome %0d value %h, got outcome %0d value %h",
                              $realtime, oc, val, rsp_outcome, rsp_read_value);
               end
            end
         end
         if (start && !busy) begin
            account_word(drv, oc, val);
            want_outcome.push_back(oc);
            want_value.push_back(val);
         end
      end
   end

   // watchdog: cycles with neither a word taken nor a response shown
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sender: holds start until the word is taken, then maybe idles.
   // ---------------------------------------------------------------------
   task automatic send_word(input io_word_type w);
      drv <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // default word: registered owner, process 5, category 3, now at clock_ns, rest zero; callers fill what matters
   function automatic io_word_type base_word(logic [1:0] op, logic [63:0] tid);
      io_word_type w;
      w = '0;
      w.op = op;
      w.tid = tid;
      w.registered = 1'b1;
      w.owner = 1'b1;
      w.cat = 3'd3;
      w.proc = 4'd5;
      w.now = clock_ns;
      return w;
   endfunction

   task automatic send_op(input logic [1:0] op, input logic [63:0] tid,
                          input logic [2:0] cat, input logic wr, input logic signed [31:0] rb);
      io_word_type w;
      clock_ns += 64'($urandom_range(1, 3000));
      w = base_word(op, tid);
      w.cat = cat;
      w.wr = wr;
      w.rb = rb;
      send_word(w);
   endtask

   task automatic read_counter(input logic [3:0] proc, input logic [2:0] cat,
                               input logic [3:0] sel, input logic [4:0] bin);
      io_word_type w;
      w = base_word(OP_READ, '0);
      w.proc = proc;
      w.cat = cat;
      w.sel = sel;
      w.bin = bin;
      send_word(w);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_basic;
      io_word_type w;
      read_counter(4'd0, 3'd2, SEL_RD_BYTES, 5'd0);
      read_counter(4'd15, 3'd5, 4'd15, 5'd31);
      read_counter(4'd5, 3'd1, SEL_FAILED, 5'd0);   // excluded category reads zero
      w = base_word(OP_ENTER, 64'hFFFF_FFFF_FFFF_FFFF);
      w.registered = 1'b0;                          // unregistered enter is ignored
      send_word(w);
      send_op(OP_ENTER, 64'd1, 3'd3, 1'b0, 32'sd0);
      send_op(OP_ENTER, 64'd1, 3'd3, 1'b0, 32'sd0); // nested
      send_op(OP_EXIT, 64'd1, 3'd3, 1'b0, 32'sd0);
      send_op(OP_EXIT, 64'd1, 3'd3, 1'b0, 32'sd2147479552); // outermost read
      send_op(OP_ENTER, 64'd2, 3'd2, 1'b1, 32'sd0);
      send_op(OP_EXIT, 64'd2, 3'd2, 1'b1, 32'sd1);          // write
      send_op(OP_ENTER, 64'd3, 3'd5, 1'b0, 32'sd0);
      send_op(OP_EXIT, 64'd3, 3'd5, 1'b0, -32'sd4095);      // failure
      send_op(OP_ENTER, 64'd4, 3'd0, 1'b0, 32'sd0);
      send_op(OP_EXIT, 64'd4, 3'd0, 1'b0, 32'sd10);         // untracked category
      // exit with the clock running backwards: latency floored at zero
      send_op(OP_ENTER, 64'd5, 3'd4, 1'b0, 32'sd0);
      w = base_word(OP_EXIT, 64'd5);
      w.cat = 3'd4;
      w.now = '0;
      w.rb = 32'sd7;
      send_word(w);
      // huge latency from a non-owner, so it never reaches a bin
      w = base_word(OP_ENTER, 64'd6);
      w.now = '0;
      send_word(w);
      w = base_word(OP_EXIT, 64'd6);
      w.now = 64'hFFFF_FFFF_FFFF_FFFF;
      w.owner = 1'b0;                               // not the owner: freed, not counted
      send_word(w);
      send_op(OP_EXIT, 64'd77, 3'd3, 1'b0, 32'sd0); // unpaired, registered
      w = base_word(OP_EXIT, 64'd78);
      w.registered = 1'b0;
      send_word(w);                                 // unpaired, unregistered
      send_word(base_word(OP_UNUSED, 64'd0));       // unused operation
      read_counter(4'd5, 3'd3, SEL_RD_BYTES, 5'd0);
      read_counter(4'd5, 3'd2, SEL_WR_HIST, 5'd0);
      read_counter(4'd5, 3'd5, SEL_FAILED, 5'd0);
      read_counter(4'd5, 3'd4, SEL_RD_HIST, 5'd0);
      read_counter(4'd0, 3'd0, SEL_UNPAIRED, 5'd0);
   endtask

   // 258 enters (one recorded, 257 nested) pin the depth at its ceiling; 257 exits unwind it, the last one unpaired
   task automatic test_nesting_saturation;
      repeat (258) send_op(OP_ENTER, 64'hABCD, 3'd2, 1'b0, 32'sd0);
      repeat (257) send_op(OP_EXIT, 64'hABCD, 3'd2, 1'b0, 32'sd5);
   endtask

   task automatic test_table_full;
      for (int i = 0; i < ENTRIES + 2; i++)
         send_op(OP_ENTER, 64'h1000 + i, 3'd3, 1'b1, 32'sd0);
      read_counter(4'd0, 3'd0, SEL_OVERFLOW, 5'd0);
      for (int i = ENTRIES + 1; i >= 0; i--)
         send_op(OP_EXIT, 64'h1000 + i, 3'd3, 1'b1, 32'sd100);
   endtask

   function automatic io_word_type random_word();
      io_word_type w;
      int pick;
      pick = $urandom_range(99);
      w.op = (pick < 42) ? OP_ENTER : (pick < 84) ? OP_EXIT : (pick < 96) ? OP_READ
                                                                        : OP_UNUSED;
      w.tid = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                        : tid_pool[$urandom_range(71)];
      w.registered = ($urandom_range(9) != 0);
      w.owner = ($urandom_range(9) != 0);
      w.proc = 4'($urandom_range(15));
      w.proc = ($urandom_range(3) == 0) ? w.proc : {2'b00, w.proc[1:0]};
      w.cat = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2, 5));
      w.wr = 1'($urandom_range(1));
      case ($urandom_range(9))
         0: w.rb = -32'sd1 * $signed(32'($urandom_range(1, 4095)));
         1: w.rb = 32'sd2147479552;
         default: w.rb = $signed(32'($urandom_range(0, 2147479552)));
      endcase
      if ($urandom_range(19) == 0) w.now = {$urandom, $urandom};
      else begin
         clock_ns += 64'($urandom_range(0, 1 << $urandom_range(0, 20)));
         w.now = clock_ns;
      end
      w.sel = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10));
      w.bin = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(12));
      return w;
   endfunction

   task automatic test_random(input int count);
      repeat (count) send_word(random_word());
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      drv = '0;
      overflow_total = '0;
      unpaired_total = '0;
      for (int i = 0; i < ENTRIES; i++) live_valid[i] = 1'b0;
      for (int i = 0; i < STAT_WORDS; i++) stats[i] = '0;
      for (int i = 0; i < 72; i++) tid_pool[i] = {$urandom, $urandom};
      tid_pool[0] = '0;
      tid_pool[1] = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      test_basic;
      test_nesting_saturation;
      test_table_full;
      test_random(170);
      send_idle_pct = 69;
      test_random(170);
      send_idle_pct = 0;
      test_random(170);
      start <= 1'b0;

      // drain, then look for stray responses
      while (want_outcome.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

### files.f
rtl/core/iolam_pkg.sv
rtl/core/iolam_ram.sv
rtl/core/iolam_bucket.sv
rtl/core/io_latency_accounting_monitor_top.sv
tb/tb.sv
